// ===== rtl/fcpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpwm_pkg
// Shared types and constants of the four-channel PWM timer with duty scaling.
// ----------------------------------------------------------------------------
package fcpwm_pkg;

   // Field widths.
   localparam int CNT_W     = 16;
   localparam int CHAN_W    = 8;
   localparam int DUTY_IN_W = 16;
   localparam int CMP_W     = 17;
   localparam int OUT_CH    = 4;

   // Full-scale duty, in thousandths.
   localparam int MAX_DUTY = 1000;
   localparam int DUTY_W   = $clog2(MAX_DUTY + 1);

   // The product (period + 1) * duty is below 2^PROD_W.
   localparam int PROD_W = CMP_W + DUTY_W;

   // Exact floor division by MAX_DUTY for any value below 2^PROD_W.
   // The value is multiplied by ceil(2^(PROD_W + L) / MAX_DUTY), where
   // 2^L >= MAX_DUTY, and then shifted right by PROD_W + L.
   localparam int DIV_L     = $clog2(MAX_DUTY);
   localparam int DIV_SHIFT = PROD_W + DIV_L;
   localparam int RECIP_W   = PROD_W + 1;
   localparam int MULQ_W    = PROD_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << DIV_SHIFT) + 64'(MAX_DUTY) - 64'd1) / 64'(MAX_DUTY);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   // Reset value of the period register.
   localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd3599;

   // Operation codes of an input word.
   typedef enum logic {
      FUNC_TICK = 1'b0,
      FUNC_DUTY = 1'b1
   } func_type;

endpackage

// ===== rtl/four_channel_pwm_with_duty_scaling_top.sv =====
// ----------------------------------------------------------------------------
// four_channel_pwm_with_duty_scaling_top
// Four-channel edge-aligned PWM timer with a shared up-counter, preloaded
// compares and duty-to-compare scaling.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the result side is not stalled,
// and returns one result word per input word. An accepted word passes from
// the input register through the product register into the result register.
// The path is a three-register pipeline: an input register, a register that
// holds the product (period + 1) * clamped duty, and the result register.
// Division by the full-scale duty, the preload write, the counter step, the
// update event and the output compare all happen between the product
// register and the result register, so a duty write is always in the preload
// before any later tick can copy it. Each stage moves forward when the stage
// after it is empty or moves too, so bubbles close up while a result waits.
// The user must write the period register through the csr port only while
// the block is idle (not enforced). A new period applies to the next tick.
// ----------------------------------------------------------------------------
module four_channel_pwm_with_duty_scaling_top
   import fcpwm_pkg::*;
#(
   parameter int NUM_CHANNELS = 4
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CNT_W-1:0]     csr_wdata,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [CHAN_W-1:0]    req_channel,
   input  logic [DUTY_IN_W-1:0] req_duty,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_pwm_out1,
   output logic                 rsp_pwm_out2,
   output logic                 rsp_pwm_out3,
   output logic                 rsp_pwm_out4,
   output logic [CNT_W-1:0]     rsp_counter_value
);

   // Timer state.
   logic [CNT_W-1:0]                     period_ff, period_in;
   logic [CNT_W-1:0]                     counter_ff, counter_in;
   logic [NUM_CHANNELS-1:0][CMP_W-1:0]   preload_ff, preload_in;
   logic [NUM_CHANNELS-1:0][CMP_W-1:0]   active_ff, active_in;

   // Stage 1: input register.
   logic                                 s1_valid_ff, s1_valid_in;
   func_type                             s1_func_ff, s1_func_in;
   logic [CHAN_W-1:0]                    s1_channel_ff, s1_channel_in;
   logic [DUTY_IN_W-1:0]                 s1_duty_ff, s1_duty_in;

   // Stage 2: product register.
   logic                                 s2_valid_ff, s2_valid_in;
   func_type                             s2_func_ff, s2_func_in;
   logic [NUM_CHANNELS-1:0]              s2_wmask_ff, s2_wmask_in;
   logic [PROD_W-1:0]                    s2_prod_ff, s2_prod_in;

   // Result register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_CH-1:0]                    pwm_ff, pwm_in;
   logic [CNT_W-1:0]                     cnt_out_ff, cnt_out_in;

   // Handshake and datapath nets.
   logic                                 out_ready;
   logic                                 s2_ready;
   logic                                 s1_ready;
   logic                                 s2_adv;
   logic                                 tick_fire;
   logic                                 update_fire;
   logic [CMP_W-1:0]                     period_plus_one;
   logic [DUTY_W-1:0]                    duty_clamped;
   logic [MULQ_W-1:0]                    quot_full;
   logic [CMP_W-1:0]                     scaled;
   logic [CNT_W-1:0]                     cnt_next;
   logic [NUM_CHANNELS-1:0][CMP_W-1:0]   active_next;

   // Pipeline flow control: a stage loads when it is empty or drains.
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s2_adv    = s2_valid_ff && out_ready;
   assign req_ready = s1_ready;
   assign csr_ready = 1'b1;

   // Period register write.
   always_comb begin
      period_in = period_ff;
      if (csr_valid && csr_ready) begin
         period_in = csr_wdata;
      end
   end

   // Stage 1 load.
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_func_in    = s1_func_ff;
      s1_channel_in = s1_channel_ff;
      s1_duty_in    = s1_duty_ff;
      if (s1_ready) begin
         s1_valid_in   = req_valid;
         s1_func_in    = func_type'(req_func);
         s1_channel_in = req_channel;
         s1_duty_in    = req_duty;
      end
   end

   // Stage 1 work: clamp the duty, form the product and decode the channel.
   assign period_plus_one = {1'b0, period_ff} + CMP_W'(1);
   assign duty_clamped    = (s1_duty_ff > DUTY_IN_W'(MAX_DUTY)) ?
                            DUTY_W'(MAX_DUTY) : s1_duty_ff[DUTY_W-1:0];

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_func_in  = s2_func_ff;
      s2_wmask_in = s2_wmask_ff;
      s2_prod_in  = s2_prod_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
         s2_func_in  = s1_func_ff;
         s2_prod_in  = PROD_W'(period_plus_one) * PROD_W'(duty_clamped);
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            s2_wmask_in[i] = (s1_func_ff == FUNC_DUTY) &&
                             (s1_channel_ff == CHAN_W'(i + 1));
         end
      end
   end

   // Stage 2 work: divide by the full scale through the reciprocal.
   assign quot_full = MULQ_W'(s2_prod_ff) * MULQ_W'(RECIP);
   assign scaled    = quot_full[DIV_SHIFT +: CMP_W];

   // Counter step and update event, taken when the word leaves stage 2.
   assign tick_fire   = s2_adv && (s2_func_ff == FUNC_TICK);
   assign update_fire = tick_fire && (counter_ff >= period_ff);

   always_comb begin
      cnt_next = counter_ff;
      if (update_fire) begin
         cnt_next = '0;
      end else if (tick_fire) begin
         cnt_next = counter_ff + CNT_W'(1);
      end
   end

   assign active_next = update_fire ? preload_ff : active_ff;
   assign counter_in  = cnt_next;
   assign active_in   = active_next;

   // Preload write for the addressed channel.
   always_comb begin
      preload_in = preload_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (s2_adv && s2_wmask_ff[i]) begin
            preload_in[i] = scaled;
         end
      end
   end

   // Output levels: high while the counter is below the active compare.
   for (genvar k = 0; k < OUT_CH; k++) begin : g_out
      if (k < NUM_CHANNELS) begin : g_used
         assign pwm_in[k] = s2_adv ? ({1'b0, cnt_next} < active_next[k]) :
                                     pwm_ff[k];
      end else begin : g_unused
         assign pwm_in[k] = 1'b0;
      end
   end

   // Result register load.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      cnt_out_in   = cnt_out_ff;
      if (out_ready) begin
         rsp_valid_in = s2_valid_ff;
         cnt_out_in   = cnt_next;
      end
   end

   // Control state and timer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= PERIOD_RESET;
         counter_ff   <= '0;
         preload_ff   <= '0;
         active_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         period_ff    <= period_in;
         counter_ff   <= counter_in;
         preload_ff   <= preload_in;
         active_ff    <= active_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_func_ff    <= s1_func_in;
      s1_channel_ff <= s1_channel_in;
      s1_duty_ff    <= s1_duty_in;
      s2_func_ff    <= s2_func_in;
      s2_wmask_ff   <= s2_wmask_in;
      s2_prod_ff    <= s2_prod_in;
      pwm_ff        <= pwm_in;
      cnt_out_ff    <= cnt_out_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pwm_out1      = pwm_ff[0];
   assign rsp_pwm_out2      = pwm_ff[1];
   assign rsp_pwm_out3      = pwm_ff[2];
   assign rsp_pwm_out4      = pwm_ff[3];
   assign rsp_counter_value = cnt_out_ff;

   // A held result always shows the counter that the timer currently has.
   a_rsp_matches_counter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (cnt_out_ff == counter_ff))
      else $error("result counter differs from timer counter");

   // An update event always restarts the counter.
   a_update_wraps: assert property (@(posedge clock) disable iff (reset)
      update_fire |=> (counter_ff == '0))
      else $error("counter did not wrap on update event");

   // Active compares change only on an update event.
   a_active_hold: assert property (@(posedge clock) disable iff (reset)
      !update_fire |=> $stable(active_ff))
      else $error("active compare changed without update event");

   // Preloads change only when a duty write leaves the pipeline.
   a_preload_hold: assert property (@(posedge clock) disable iff (reset)
      !(s2_adv && (s2_func_ff == FUNC_DUTY)) |=> $stable(preload_ff))
      else $error("preload changed without a duty write");

   // An empty pipeline always takes input.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && !s2_valid_ff) |-> req_ready)
      else $error("empty pipeline refused input");

endmodule
